// File: hw/rtl/cpd_pkg.sv
package cpd_pkg;

  localparam logic [7:0] SYNC_BYTE  = 8'hAA;
  localparam logic [7:0] MIN_LENGTH = 8'd2;

  // result event codes
  typedef enum logic [1:0] {
    EV_PARAM = 2'd0,
    EV_OK    = 2'd1,
    EV_BAD   = 2'd2,
    EV_ERROR = 2'd3
  } event_t;

  // one result beat as produced by the parser
  typedef struct packed {
    logic       vld;
    event_t     ev;
    logic [7:0] data;
    logic [7:0] id;
    logic [7:0] ctrl;
    logic [7:0] idx;
    logic [7:0] cnt;
  } res_t;

endpackage

// File: hw/rtl/cpd_if.sv
// received byte channel
interface cpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// result channel
interface cpd_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [7:0] data_byte;
  logic [7:0] frame_id;
  logic [7:0] frame_ctrl;
  logic [7:0] param_index;
  logic [7:0] param_count;

  modport source (output valid, output event_res, output data_byte, output frame_id,
                  output frame_ctrl, output param_index, output param_count,
                  input ready);
  modport sink   (input valid, input event_res, input data_byte, input frame_id,
                  input frame_ctrl, input param_index, input param_count,
                  output ready);
endinterface

// File: hw/rtl/cpd_parser.sv
module cpd_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [7:0]    rx_byte,
  output cpd_pkg::res_t res
);
  import cpd_pkg::*;

  typedef enum logic [2:0] {
    PH_SYNC1 = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_LEN   = 3'd2,
    PH_ID    = 3'd3,
    PH_CTRL  = 3'd4,
    PH_PARAM = 3'd5,
    PH_CHECK = 3'd6
  } phase_t;

  phase_t     phase;
  logic [7:0] running_sum;
  logic [7:0] param_count;
  logic [7:0] bytes_left;
  logic [7:0] held_id;
  logic [7:0] held_ctrl;
  logic [7:0] param_position;

  logic [7:0] sum_next;

  assign sum_next = running_sum + rx_byte;

  // result for the byte currently offered
  always_comb begin
    res      = '0;
    res.data = rx_byte;
    res.ev   = EV_ERROR;
    case (phase)
      PH_SYNC2: begin
        res.vld = (rx_byte != SYNC_BYTE);
      end
      PH_LEN: begin
        res.vld = (rx_byte < MIN_LENGTH);
      end
      PH_ID, PH_CTRL: begin
        res.vld = 1'b0;
      end
      PH_PARAM: begin
        res.vld  = 1'b1;
        res.ev   = EV_PARAM;
        res.id   = held_id;
        res.ctrl = held_ctrl;
        res.idx  = param_position;
        res.cnt  = param_count;
      end
      PH_CHECK: begin
        // byte matches 256 minus the sum exactly when the total wraps to zero
        res.vld  = 1'b1;
        res.ev   = (sum_next == 8'd0) ? EV_OK : EV_BAD;
        res.id   = held_id;
        res.ctrl = held_ctrl;
        res.cnt  = param_count;
      end
      default: begin
        res.vld = (rx_byte != SYNC_BYTE);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SYNC1;
      running_sum    <= '0;
      param_count    <= '0;
      bytes_left     <= '0;
      held_id        <= '0;
      held_ctrl      <= '0;
      param_position <= '0;
    end else if (take) begin
      case (phase)
        PH_SYNC2: begin
          phase <= (rx_byte == SYNC_BYTE) ? PH_LEN : PH_SYNC1;
        end
        PH_LEN: begin
          param_count <= rx_byte - MIN_LENGTH;
          bytes_left  <= rx_byte - MIN_LENGTH;
          phase       <= (rx_byte < MIN_LENGTH) ? PH_SYNC1 : PH_ID;
        end
        PH_ID: begin
          held_id     <= rx_byte;
          running_sum <= rx_byte;
          phase       <= PH_CTRL;
        end
        PH_CTRL: begin
          held_ctrl      <= rx_byte;
          running_sum    <= sum_next;
          param_position <= '0;
          phase          <= (bytes_left == 8'd0) ? PH_CHECK : PH_PARAM;
        end
        PH_PARAM: begin
          running_sum    <= sum_next;
          param_position <= param_position + 8'd1;
          bytes_left     <= bytes_left - 8'd1;
          if (bytes_left == 8'd1) begin
            phase <= PH_CHECK;
          end
        end
        PH_CHECK: begin
          phase <= PH_SYNC1;
        end
        default: begin
          phase <= (rx_byte == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/checksummed_packet_deframer.sv
// Checksummed packet deframer. Takes one received byte per beat on rx and
// recognizes frames of the form 0xAA, 0xAA, length, id, control, (length - 2)
// parameter bytes, checksum, where the checksum is 256 minus the 8-bit sum of
// id, control and parameters. Each parameter byte produces a result beat on
// res carrying the frame's id, control, its index and the parameter count; the
// checksum byte produces a frame-ok or checksum-bad beat; a bad sync byte or a
// length below two produces an error beat (offending byte in data_byte) and a
// return to hunting. Sync, length, id and control bytes produce no beat.
// Throughput is one byte per clock: the parser state updates in the cycle a
// byte is accepted and its result lands in a single output register, so the
// result beat of an accepted byte appears in the cycle after it. rx stalls
// only while that output register holds a beat that res has not taken.
module checksummed_packet_deframer (
  input  logic           clk,
  input  logic           rst,
  cpd_byte_if.sink       rx,
  cpd_res_if.source      res
);
  import cpd_pkg::*;

  logic   take;
  res_t   parse_res;

  // output register
  logic       out_valid;
  event_t     out_ev;
  logic [7:0] out_data;
  logic [7:0] out_id;
  logic [7:0] out_ctrl;
  logic [7:0] out_idx;
  logic [7:0] out_cnt;

  // accept a byte whenever the output register is free or draining this cycle
  assign rx.ready = !out_valid || res.ready;
  assign take     = rx.valid && rx.ready;

  cpd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx.rx_byte),
    .res     (parse_res)
  );

  // valid flag of the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= parse_res.vld;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload loads only with an accepted byte, so a stalled beat holds
  always_ff @(posedge clk) begin
    if (take) begin
      out_ev   <= parse_res.ev;
      out_data <= parse_res.data;
      out_id   <= parse_res.id;
      out_ctrl <= parse_res.ctrl;
      out_idx  <= parse_res.idx;
      out_cnt  <= parse_res.cnt;
    end
  end

  assign res.valid       = out_valid;
  assign res.event_res   = out_ev;
  assign res.data_byte   = out_data;
  assign res.frame_id    = out_id;
  assign res.frame_ctrl  = out_ctrl;
  assign res.param_index = out_idx;
  assign res.param_count = out_cnt;

endmodule

// File: hw/rtl/cpd_checker.sv
module cpd_checker (
  input logic       clk,
  input logic       rst,
  input logic       rx_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] event_res,
  input logic [7:0] data_byte,
  input logic [7:0] frame_id,
  input logic [7:0] frame_ctrl,
  input logic [7:0] param_index,
  input logic [7:0] param_count
);
  import cpd_pkg::*;

  // a stalled result beat holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(event_res) && $stable(data_byte)
      && $stable(frame_id) && $stable(param_index))
    else $error("result beat changed while stalled");

  // input is never blocked while the output is empty
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> rx_ready)
    else $error("rx stalled with empty output");

  // error beats carry no frame context
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && event_res == EV_ERROR |->
      frame_id == 8'd0 && frame_ctrl == 8'd0 && param_index == 8'd0 && param_count == 8'd0)
    else $error("error beat with frame fields");

  // parameter index stays inside the frame
  a_param_index: assert property (@(posedge clk) disable iff (rst)
    res_valid && event_res == EV_PARAM |-> param_index < param_count)
    else $error("parameter index out of range");

  // frame end reports index zero
  a_end_index: assert property (@(posedge clk) disable iff (rst)
    res_valid && (event_res == EV_OK || event_res == EV_BAD) |-> param_index == 8'd0)
    else $error("frame end with nonzero index");

endmodule

bind checksummed_packet_deframer cpd_checker u_cpd_checker (
  .clk         (clk),
  .rst         (rst),
  .rx_ready    (rx.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .event_res   (res.event_res),
  .data_byte   (res.data_byte),
  .frame_id    (res.frame_id),
  .frame_ctrl  (res.frame_ctrl),
  .param_index (res.param_index),
  .param_count (res.param_count)
);
